### rtl/bca_pkg.sv
// shared types and constants for the bcd alarm clock
`timescale 1ns / 1ps

package bca_pkg;

    localparam int TPS_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [TPS_W-1:0] TPS_RESET = 16'd10;

    // register index, taken from paddr[2]
    localparam logic REG_TICK_RATE = 1'b0;

    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_SET_TIME     = 3'd1,
        CMD_SET_ALARM    = 3'd2,
        CMD_ENABLE       = 3'd3,
        CMD_DISABLE      = 3'd4,
        CMD_SNOOZE_MIN   = 3'd5,
        CMD_SNOOZE_ALARM = 3'd6
    } cmd_code_t;

    typedef struct packed {
        logic [3:0] ht;
        logic [3:0] ho;
        logic [3:0] mt;
        logic [3:0] mo;
        logic [3:0] st;
        logic [3:0] so;
    } bcd_time_t;

    typedef struct packed {
        logic [3:0] ht;
        logic [3:0] ho;
        logic [3:0] mt;
        logic [3:0] mo;
    } alarm_time_t;

    typedef struct packed {
        logic [2:0]  command;
        bcd_time_t   digits;
        logic [5:0]  snooze_minutes;
    } cmd_req_t;

    typedef struct packed {
        bcd_time_t   digits;
        logic        time_valid;
        logic        alarm_valid;
        logic        alarm_on;
        logic        snoozed;
        logic        ringing;
        logic        alarm_fire;
    } clock_res_t;

    typedef struct packed {
        logic [TPS_W-1:0] subsec;
        bcd_time_t        now;
        alarm_time_t      alarm;
        bcd_time_t        snooze;
        logic             time_ok;
        logic             alarm_ok;
        logic             enabled;
        logic             pending;
        logic             sounded;
        logic             ringing;
    } clock_state_t;

endpackage

### rtl/bca_cmd_if.sv
// command request channel
`timescale 1ns / 1ps

interface bca_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [3:0] hour_tens_in;
    logic [3:0] hour_ones_in;
    logic [3:0] minute_tens_in;
    logic [3:0] minute_ones_in;
    logic [3:0] second_tens_in;
    logic [3:0] second_ones_in;
    logic [5:0] snooze_minutes;

    modport source (
        output valid, command, hour_tens_in, hour_ones_in, minute_tens_in,
               minute_ones_in, second_tens_in, second_ones_in, snooze_minutes,
        input  ready
    );

    modport sink (
        input  valid, command, hour_tens_in, hour_ones_in, minute_tens_in,
               minute_ones_in, second_tens_in, second_ones_in, snooze_minutes,
        output ready
    );
endinterface

### rtl/bca_res_if.sv
// result channel: time digits and status flags
`timescale 1ns / 1ps

interface bca_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;
    logic [3:0] second_tens;
    logic [3:0] second_ones;
    logic       time_valid;
    logic       alarm_valid;
    logic       alarm_on;
    logic       snoozed;
    logic       ringing;
    logic       alarm_fire;

    modport source (
        output valid, hour_tens, hour_ones, minute_tens, minute_ones, second_tens,
               second_ones, time_valid, alarm_valid, alarm_on, snoozed, ringing,
               alarm_fire,
        input  ready
    );

    modport sink (
        input  valid, hour_tens, hour_ones, minute_tens, minute_ones, second_tens,
               second_ones, time_valid, alarm_valid, alarm_on, snoozed, ringing,
               alarm_fire,
        output ready
    );
endinterface

### rtl/bcd_alarm_clock.sv
// top level of the bcd alarm clock
`timescale 1ns / 1ps

// 24-hour bcd clock with one alarm and snooze.
// cmd: one request per command (tick, set time, set alarm, enable, disable,
//   snooze by minutes, snooze to alarm time), valid/ready handshake.
// res: exactly one result per request, in order, with the time digits and
//   status flags after the update and a one-result alarm_fire pulse.
// apb port: tick rate register at byte address 0, written only while idle;
//   the user must ensure this, the block itself does not enforce it.
// a request is latched in an input register; once res can accept, the
//   single pass of bcd update logic writes clock state and result register.
// one request per cycle while res.ready; the clock state lives only in the
//   result stage, so back-to-back commands see each other's updates.
// when res stalls the result register holds and the input register still
//   takes one more request; cmd.ready then drops until res drains.
// reset clears the state to 00:00:00 with time and alarm not valid and
//   the tick rate to 10; no result is pending after reset.
module bcd_alarm_clock (
    input  logic                           clk,
    input  logic                           rst_n,
    bca_cmd_if.sink                        cmd,
    bca_res_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bca_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bca_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bca_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import bca_pkg::*;

    logic [TPS_W-1:0] tps;
    cmd_req_t         req_in;
    cmd_req_t         req_reg;
    logic             req_vld_reg;
    clock_state_t     state_reg;
    clock_state_t     state_next;
    clock_res_t       res_next;
    clock_res_t       res_reg;
    logic             res_vld_reg;
    logic             advance;
    logic             cmd_take;

    bca_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tps     (tps)
    );

    bca_step u_step (
        .cur (state_reg),
        .req (req_reg),
        .tps (tps),
        .nxt (state_next),
        .res (res_next)
    );

    always_comb
    begin
        req_in.command        = cmd.command;
        req_in.digits.ht      = cmd.hour_tens_in;
        req_in.digits.ho      = cmd.hour_ones_in;
        req_in.digits.mt      = cmd.minute_tens_in;
        req_in.digits.mo      = cmd.minute_ones_in;
        req_in.digits.st      = cmd.second_tens_in;
        req_in.digits.so      = cmd.second_ones_in;
        req_in.snooze_minutes = cmd.snooze_minutes;
    end

    assign advance   = req_vld_reg && (!res_vld_reg || res.ready);
    assign cmd.ready = !req_vld_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else if (cmd_take)
        begin
            req_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            req_reg <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            res_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid       = res_vld_reg;
    assign res.hour_tens   = res_reg.digits.ht;
    assign res.hour_ones   = res_reg.digits.ho;
    assign res.minute_tens = res_reg.digits.mt;
    assign res.minute_ones = res_reg.digits.mo;
    assign res.second_tens = res_reg.digits.st;
    assign res.second_ones = res_reg.digits.so;
    assign res.time_valid  = res_reg.time_valid;
    assign res.alarm_valid = res_reg.alarm_valid;
    assign res.alarm_on    = res_reg.alarm_on;
    assign res.snoozed     = res_reg.snoozed;
    assign res.ringing     = res_reg.ringing;
    assign res.alarm_fire  = res_reg.alarm_fire;

endmodule

### rtl/bca_cfg_regs.sv
// apb configuration register: ticks per second
`timescale 1ns / 1ps

module bca_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bca_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bca_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bca_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [bca_pkg::TPS_W-1:0]      tps
);
    import bca_pkg::*;

    logic [TPS_W-1:0] tps_reg;
    logic             reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready
                     && (reg_idx == REG_TICK_RATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (wr_en)
        begin
            tps_reg <= pwdata[TPS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (psel && (reg_idx == REG_TICK_RATE))
        begin
            prdata = {{(CFG_DATA_W-TPS_W){1'b0}}, tps_reg};
        end
    end

    assign tps = tps_reg;

endmodule

### rtl/bca_step.sv
// next-state and result logic for one command
`timescale 1ns / 1ps

module bca_step (
    input  bca_pkg::clock_state_t      cur,
    input  bca_pkg::cmd_req_t          req,
    input  logic [bca_pkg::TPS_W-1:0]  tps,
    output bca_pkg::clock_state_t      nxt,
    output bca_pkg::clock_res_t        res
);
    import bca_pkg::*;

    function automatic logic legal_time(input bcd_time_t t);
        logic digits_ok;
        logic hour_ok;
        digits_ok = (t.ht <= 4'd9) && (t.ho <= 4'd9) && (t.mo <= 4'd9)
                    && (t.so <= 4'd9);
        hour_ok = (t.ht < 4'd2) || ((t.ht == 4'd2) && (t.ho <= 4'd3));
        return digits_ok && hour_ok && (t.mt <= 4'd5) && (t.st <= 4'd5);
    endfunction

    // plain bcd carry chain, midnight handled by the caller
    function automatic bcd_time_t inc_second(input bcd_time_t t);
        bcd_time_t r;
        r = t;
        if (t.so < 4'd9)
        begin
            r.so = t.so + 4'd1;
        end
        else
        begin
            r.so = 4'd0;
            if (t.st < 4'd5)
            begin
                r.st = t.st + 4'd1;
            end
            else
            begin
                r.st = 4'd0;
                if (t.mo < 4'd9)
                begin
                    r.mo = t.mo + 4'd1;
                end
                else
                begin
                    r.mo = 4'd0;
                    if (t.mt < 4'd5)
                    begin
                        r.mt = t.mt + 4'd1;
                    end
                    else
                    begin
                        r.mt = 4'd0;
                        if (t.ho < 4'd9)
                        begin
                            r.ho = t.ho + 4'd1;
                        end
                        else
                        begin
                            r.ho = 4'd0;
                            r.ht = t.ht + 4'd1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // add minutes to a time, keep seconds, wrap at 24 hours
    function automatic bcd_time_t add_minutes(input bcd_time_t b,
                                              input logic [5:0] m);
        bcd_time_t   r;
        logic [6:0]  mins;
        logic [6:0]  hrs;
        logic [1:0]  hcarry;
        logic [3:0]  mt;
        logic [3:0]  ht;
        r = b;
        mins = ({3'b000, b.mt} << 3) + ({3'b000, b.mt} << 1) + {3'b000, b.mo}
               + {1'b0, m};
        hcarry = 2'd0;
        if (mins >= 7'd120)
        begin
            mins = mins - 7'd120;
            hcarry = 2'd2;
        end
        else if (mins >= 7'd60)
        begin
            mins = mins - 7'd60;
            hcarry = 2'd1;
        end
        if (mins >= 7'd50)
        begin
            mt = 4'd5;
        end
        else if (mins >= 7'd40)
        begin
            mt = 4'd4;
        end
        else if (mins >= 7'd30)
        begin
            mt = 4'd3;
        end
        else if (mins >= 7'd20)
        begin
            mt = 4'd2;
        end
        else if (mins >= 7'd10)
        begin
            mt = 4'd1;
        end
        else
        begin
            mt = 4'd0;
        end
        mins = mins - (({3'b000, mt} << 3) + ({3'b000, mt} << 1));
        hrs = ({3'b000, b.ht} << 3) + ({3'b000, b.ht} << 1) + {3'b000, b.ho}
              + {5'b00000, hcarry};
        if (hrs >= 7'd24)
        begin
            hrs = hrs - 7'd24;
        end
        if (hrs >= 7'd20)
        begin
            ht = 4'd2;
        end
        else if (hrs >= 7'd10)
        begin
            ht = 4'd1;
        end
        else
        begin
            ht = 4'd0;
        end
        hrs = hrs - (({3'b000, ht} << 3) + ({3'b000, ht} << 1));
        r.ht = ht;
        r.ho = hrs[3:0];
        r.mt = mt;
        r.mo = mins[3:0];
        return r;
    endfunction

    localparam bcd_time_t LAST_SECOND = '{
        ht: 4'd2, ho: 4'd3, mt: 4'd5, mo: 4'd9, st: 4'd5, so: 4'd9
    };

    logic [TPS_W-1:0] subsec_inc;
    bcd_time_t        alarm_full;
    bcd_time_t        set_alarm_full;
    logic             fire;

    assign subsec_inc     = cur.subsec + {{(TPS_W-1){1'b0}}, 1'b1};
    assign alarm_full     = {cur.alarm, 4'd0, 4'd0};
    assign set_alarm_full = {req.digits.ht, req.digits.ho, req.digits.mt,
                             req.digits.mo, 4'd0, 4'd0};

    always_comb
    begin
        nxt  = cur;
        fire = 1'b0;
        case (cmd_code_t'(req.command))
            CMD_TICK:
            begin
                if (cur.time_ok)
                begin
                    if (subsec_inc >= tps)
                    begin
                        nxt.subsec = '0;
                        if (cur.now == LAST_SECOND)
                        begin
                            nxt.now     = '0;
                            nxt.sounded = 1'b0;
                        end
                        else
                        begin
                            nxt.now = inc_second(cur.now);
                        end
                    end
                    else
                    begin
                        nxt.subsec = subsec_inc;
                    end
                    // a pending snooze takes the place of the alarm compare
                    if (cur.pending)
                    begin
                        if (nxt.now == cur.snooze)
                        begin
                            nxt.pending = 1'b0;
                            nxt.sounded = 1'b1;
                            nxt.ringing = 1'b1;
                            fire        = cur.enabled;
                        end
                    end
                    else if (cur.enabled && cur.alarm_ok && !nxt.sounded
                             && (nxt.now == alarm_full))
                    begin
                        nxt.sounded = 1'b1;
                        nxt.ringing = 1'b1;
                        fire        = 1'b1;
                    end
                end
            end
            CMD_SET_TIME:
            begin
                if (legal_time(req.digits))
                begin
                    nxt.now     = req.digits;
                    nxt.time_ok = 1'b1;
                end
                else
                begin
                    nxt.time_ok = 1'b0;
                end
            end
            CMD_SET_ALARM:
            begin
                nxt.alarm    = set_alarm_full[23:8];
                nxt.alarm_ok = legal_time(set_alarm_full);
                nxt.enabled  = 1'b1;
                nxt.sounded  = 1'b0;
                nxt.ringing  = 1'b0;
            end
            CMD_ENABLE:
            begin
                nxt.enabled = 1'b1;
            end
            CMD_DISABLE:
            begin
                nxt.enabled = 1'b0;
                nxt.pending = 1'b0;
                nxt.sounded = 1'b0;
                nxt.ringing = 1'b0;
            end
            CMD_SNOOZE_MIN:
            begin
                if (cur.time_ok && (req.snooze_minutes != 6'd0))
                begin
                    nxt.snooze  = add_minutes(cur.pending ? cur.snooze : cur.now,
                                              req.snooze_minutes);
                    nxt.pending = 1'b1;
                    nxt.sounded = 1'b0;
                    nxt.ringing = 1'b0;
                end
            end
            CMD_SNOOZE_ALARM:
            begin
                if (cur.time_ok && cur.alarm_ok)
                begin
                    nxt.snooze  = alarm_full;
                    nxt.pending = 1'b1;
                    nxt.enabled = 1'b1;
                    nxt.sounded = 1'b0;
                    nxt.ringing = 1'b0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.digits      = nxt.now;
        res.time_valid  = nxt.time_ok;
        res.alarm_valid = nxt.alarm_ok;
        res.alarm_on    = nxt.enabled;
        res.snoozed     = nxt.pending;
        res.ringing     = nxt.ringing;
        res.alarm_fire  = fire;
    end

endmodule
